@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the local interrupt timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define LIT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define LIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/lit_pkg.sv @@
// Types, register map and helpers for the local interrupt timer.
`default_nettype none

package lit_pkg;

    // Width of the initial and current count registers (8..32).
    localparam int COUNT_WIDTH = 32;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // Register offsets within the window.
    localparam logic [9:0] OFS_ID       = 10'h020;
    localparam logic [9:0] OFS_SPURIOUS = 10'h0F0;
    localparam logic [9:0] OFS_TIMER    = 10'h320;
    localparam logic [9:0] OFS_ERROR    = 10'h370;
    localparam logic [9:0] OFS_INIT     = 10'h380;
    localparam logic [9:0] OFS_CURRENT  = 10'h390;
    localparam logic [9:0] OFS_DIVIDE   = 10'h3E0;

    // Bit positions.
    localparam int BIT_MASK      = 16;
    localparam int BIT_MODE_LO   = 17;
    localparam int BIT_ENABLE    = 8;
    localparam logic [3:0] DIVIDE_BITS = 4'hB;

    // Timer mode that reloads.
    localparam logic [1:0] MODE_PERIODIC = 2'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  reg_offset;
        logic [31:0] write_data;
    } lit_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        timer_irq;
        logic [7:0]  irq_vector;
    } lit_out_t;

    // Divisor of the prescaler: 2^((b3b1b0 + 1) mod 8), range 1..128.
    function automatic logic [7:0] divisor_of(input logic [3:0] code);
        logic [2:0] v;
        logic [2:0] sh;
        begin
            v  = {code[3], code[1:0]};
            sh = v + 3'd1;
            divisor_of = 8'd1 << sh;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/lit_core.sv @@
// Register window and timer state of the local interrupt timer.
`default_nettype none

module lit_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire lit_pkg::lit_in_t item,
    input  wire logic            cfg_we,
    input  wire logic [7:0]      cfg_id,
    output lit_pkg::lit_out_t    result
);
    import lit_pkg::*;

    logic [7:0]             local_id_reg;
    logic [7:0]             timer_vector_reg,  timer_vector_next;
    logic                   timer_masked_reg,  timer_masked_next;
    logic [1:0]             timer_mode_reg,    timer_mode_next;
    logic [3:0]             divide_code_reg,   divide_code_next;
    logic [COUNT_WIDTH-1:0] initial_count_reg, initial_count_next;
    logic [COUNT_WIDTH-1:0] current_count_reg, current_count_next;
    logic [6:0]             prescale_reg,      prescale_next;
    logic [7:0]             spurious_reg,      spurious_next;
    logic                   soft_enable_reg,   soft_enable_next;
    logic [7:0]             err_vector_reg,    err_vector_next;
    logic                   err_masked_reg,    err_masked_next;

    logic                   aligned;
    logic [7:0]             presc_inc;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic                   fire;
    logic [31:0]            rd;

    assign aligned   = (item.reg_offset[3:0] == 4'd0);
    assign presc_inc = {1'b0, prescale_reg} + 8'd1;
    assign count_dec = current_count_reg - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // Register read mux
    always_comb begin
        rd = '0;
        if (item.func == FUNC_READ && aligned) begin
            unique case (item.reg_offset)
                OFS_ID:       rd = {local_id_reg, 24'd0};
                OFS_SPURIOUS: rd = {23'd0, soft_enable_reg, spurious_reg};
                OFS_TIMER:    rd = {13'd0, timer_mode_reg, timer_masked_reg,
                                    8'd0, timer_vector_reg};
                OFS_ERROR:    rd = {15'd0, err_masked_reg, 8'd0, err_vector_reg};
                OFS_INIT:     rd = 32'(initial_count_reg);
                OFS_CURRENT:  rd = 32'(current_count_reg);
                OFS_DIVIDE:   rd = {28'd0, divide_code_reg};
                default:      rd = '0;
            endcase
        end
    end

    // Next state: tick or register write
    always_comb begin
        timer_vector_next  = timer_vector_reg;
        timer_masked_next  = timer_masked_reg;
        timer_mode_next    = timer_mode_reg;
        divide_code_next   = divide_code_reg;
        initial_count_next = initial_count_reg;
        current_count_next = current_count_reg;
        prescale_next      = prescale_reg;
        spurious_next      = spurious_reg;
        soft_enable_next   = soft_enable_reg;
        err_vector_next    = err_vector_reg;
        err_masked_next    = err_masked_reg;
        fire               = 1'b0;

        if (item.func == FUNC_TICK) begin
            if (current_count_reg != '0) begin
                if (presc_inc < divisor_of(divide_code_reg)) begin
                    prescale_next = presc_inc[6:0];
                end else begin
                    prescale_next = '0;
                    current_count_next = count_dec;
                    if (count_dec == '0) begin
                        if (timer_mode_reg == MODE_PERIODIC) begin
                            current_count_next = initial_count_reg;
                        end
                        fire = !timer_masked_reg && soft_enable_reg;
                    end
                end
            end
        end else if (item.func == FUNC_WRITE && aligned) begin
            unique case (item.reg_offset)
                OFS_SPURIOUS: begin
                    spurious_next    = item.write_data[7:0];
                    soft_enable_next = item.write_data[BIT_ENABLE];
                    if (!item.write_data[BIT_ENABLE]) begin
                        timer_masked_next = 1'b1;
                        err_masked_next   = 1'b1;
                    end
                end
                OFS_TIMER: begin
                    timer_vector_next = item.write_data[7:0];
                    timer_masked_next = item.write_data[BIT_MASK] || !soft_enable_reg;
                    timer_mode_next   = item.write_data[BIT_MODE_LO +: 2];
                end
                OFS_ERROR: begin
                    err_vector_next = item.write_data[7:0];
                    err_masked_next = item.write_data[BIT_MASK] || !soft_enable_reg;
                end
                OFS_INIT: begin
                    initial_count_next = item.write_data[COUNT_WIDTH-1:0];
                    current_count_next = item.write_data[COUNT_WIDTH-1:0];
                    prescale_next      = '0;
                end
                OFS_DIVIDE: begin
                    divide_code_next = item.write_data[3:0] & DIVIDE_BITS;
                end
                default: begin
                end
            endcase
        end
    end

    assign result.read_data  = rd;
    assign result.timer_irq  = fire;
    assign result.irq_vector = fire ? timer_vector_reg : 8'd0;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_id_reg      <= '0;
            timer_vector_reg  <= '0;
            timer_masked_reg  <= 1'b1;
            timer_mode_reg    <= '0;
            divide_code_reg   <= '0;
            initial_count_reg <= '0;
            current_count_reg <= '0;
            prescale_reg      <= '0;
            spurious_reg      <= 8'hFF;
            soft_enable_reg   <= 1'b0;
            err_vector_reg    <= '0;
            err_masked_reg    <= 1'b1;
        end else begin
            if (cfg_we) begin
                local_id_reg <= cfg_id;
            end
            if (step) begin
                timer_vector_reg  <= timer_vector_next;
                timer_masked_reg  <= timer_masked_next;
                timer_mode_reg    <= timer_mode_next;
                divide_code_reg   <= divide_code_next;
                initial_count_reg <= initial_count_next;
                current_count_reg <= current_count_next;
                prescale_reg      <= prescale_next;
                spurious_reg      <= spurious_next;
                soft_enable_reg   <= soft_enable_next;
                err_vector_reg    <= err_vector_next;
                err_masked_reg    <= err_masked_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/local_interrupt_timer_unit.sv @@
// Top level of the local interrupt timer: input stage, core and result register.
`default_nettype none
`include "assert_macros.svh"

// Local interrupt controller timer behind a valid/ready item stream. Each item is
// a bus tick, a register read or a register write, and each gives exactly one
// result item: read data, and the timer interrupt flag with its vector. An item
// sits in the input register, where the register window and the timer
// state are updated in a single pass, and then waits in the result register; the
// block takes one item per cycle while the result register is free, and result valid
// rises at the edge that moves the item on, which a full result register can hold back.
// The 8-bit identifier of the ID register is written through the cfg port, which
// is always ready.
module local_interrupt_timer_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire lit_pkg::lit_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lit_pkg::lit_out_t     m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_wdata
);
    import lit_pkg::*;

    logic     in_valid_reg;
    lit_in_t  in_item_reg;
    logic     out_valid_reg;
    lit_out_t out_item_reg;
    lit_out_t core_result;
    logic     out_free;
    logic     advance;

    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    lit_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg_we  (cfg_valid),
        .cfg_id  (cfg_wdata),
        .result  (core_result)
    );

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // Checks
    `LIT_ASSERT_ALWAYS(a_no_out_after_reset, aclk, $past(!aresetn) |-> !m_valid, "result valid right after reset")
    `LIT_ASSERT(a_accept_fills_stage, aclk, aresetn, (s_valid && s_ready) |=> in_valid_reg, "accepted item not held in input stage")
    `LIT_ASSERT(a_stage_holds, aclk, aresetn, (in_valid_reg && !out_free) |=> in_valid_reg, "stalled item dropped from input stage")
    `LIT_ASSERT(a_irq_not_on_read, aclk, aresetn, (m_valid && m_data.timer_irq) |-> (m_data.read_data == 32'd0), "interrupt with read data")

endmodule

`default_nettype wire
